// ===== hdl/fcs_pkg.sv =====
// Shared types and constants for the FIFO counting semaphore.
package fcs_pkg;

    localparam int CAPACITY_BITS = 16;
    localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 16'd1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_CHECK = 3'b100
    } fcs_state_t;

    typedef enum logic [0:0] {
        ALU_SUB_SAT = 1'b0,
        ALU_ADD     = 1'b1
    } alu_op_t;

endpackage

// ===== hdl/fcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fcs_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                     wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                     rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fcs_alu.sv =====
// Shared arithmetic unit: saturating release, grant add and head fit compare.
module fcs_alu import fcs_pkg::*; #(
    parameter int AMOUNT_BITS = 16
) (
    input  alu_op_t                  op,
    input  logic [AMOUNT_BITS-1:0]   held,
    input  logic [AMOUNT_BITS-1:0]   operand,
    input  logic [CAPACITY_BITS-1:0] capacity,
    output logic [AMOUNT_BITS-1:0]   result,
    output logic                     fits
);

    localparam int W = (AMOUNT_BITS > CAPACITY_BITS) ? AMOUNT_BITS : CAPACITY_BITS;

    logic [W:0] held_x;
    logic [W:0] opnd_x;
    logic [W:0] cap_x;
    logic [W:0] sum_x;

    assign held_x = (W+1)'(held);
    assign opnd_x = (W+1)'(operand);
    assign cap_x  = (W+1)'(capacity);
    assign sum_x  = held_x + opnd_x;

    // An empty count lets any request through, even one above capacity.
    assign fits = (held == '0) || ((held_x < cap_x) && (sum_x <= cap_x));

    always_comb
    begin
        case (op)
            ALU_ADD:     result = sum_x[AMOUNT_BITS-1:0];
            ALU_SUB_SAT: result = (operand >= held) ? '0 : held - operand;
            default:     result = held;
        endcase
    end

endmodule

// ===== hdl/fifo_counting_semaphore.sv =====
// Top level of the FIFO counting semaphore: sequencer, queue and output register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | input     | in_valid / in_stall  | req_type, requester_id, amount
//  out     | output    | out_valid / out_stall| grant_requester, grant_amount, rejected,
//          |           |                      | last_result
//  cfg     | input     | cfg_write_en         | cfg_write_data (capacity)
//
// An item is accepted in ST_IDLE, then each grant takes a queue read (ST_READ) and a fit
// check (ST_CHECK), and a final head check ends the item, or ST_READ alone when the queue
// has run empty. The queue RAM has one read port, read once per head check.
// A rejected request finishes in its accept cycle. Reset clears count, pointers and
// occupancy at once; capacity resets to 1. A stalled output holds the sequencer.
module fifo_counting_semaphore import fcs_pkg::*; #(
    parameter int QUEUE_DEPTH       = 16,
    parameter int REQUESTER_ID_BITS = 8,
    parameter int AMOUNT_BITS       = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [REQUESTER_ID_BITS-1:0] requester_id,
    input  logic [AMOUNT_BITS-1:0]       amount,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [REQUESTER_ID_BITS-1:0] grant_requester,
    output logic [AMOUNT_BITS-1:0]       grant_amount,
    output logic                         rejected,
    output logic                         last_result,
    input  logic                         cfg_write_en,
    input  logic [CAPACITY_BITS-1:0]     cfg_write_data
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = REQUESTER_ID_BITS + AMOUNT_BITS;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(QUEUE_DEPTH);

    fcs_state_t state_reg, state_next;
    logic [CAPACITY_BITS-1:0]     cap_reg;
    logic [AMOUNT_BITS-1:0]       held_reg, held_next;
    logic [PTR_W-1:0]             head_reg, head_next;
    logic [PTR_W-1:0]             tail_reg, tail_next;
    logic [OCC_W-1:0]             occ_reg, occ_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [REQUESTER_ID_BITS-1:0] pend_who_reg, pend_who_next;
    logic [AMOUNT_BITS-1:0]       pend_amt_reg, pend_amt_next;
    logic                         out_valid_reg, out_valid_next;
    logic [REQUESTER_ID_BITS-1:0] out_who_reg, out_who_next;
    logic [AMOUNT_BITS-1:0]       out_amt_reg, out_amt_next;
    logic                         out_rej_reg, out_rej_next;
    logic                         out_last_reg, out_last_next;

    logic                         out_free;
    logic                         in_accept;
    logic [AMOUNT_BITS-1:0]       amt_eff;
    logic                         ram_we;
    logic                         ram_re;
    logic [ENTRY_W-1:0]           ram_rdata;
    logic [REQUESTER_ID_BITS-1:0] rd_who;
    logic [AMOUNT_BITS-1:0]       rd_amt;
    alu_op_t                      alu_op;
    logic [AMOUNT_BITS-1:0]       alu_operand;
    logic [AMOUNT_BITS-1:0]       alu_result;
    logic                         alu_fits;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign amt_eff   = (amount == '0) ? AMOUNT_BITS'(1) : amount;
    assign rd_who    = ram_rdata[ENTRY_W-1 -: REQUESTER_ID_BITS];
    assign rd_amt    = ram_rdata[AMOUNT_BITS-1:0];
    assign ram_we    = in_accept && !req_type && (occ_reg != FULL_OCC);

    fcs_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata ({requester_id, amt_eff}),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    fcs_alu #(
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_alu (
        .op       (alu_op),
        .held     (held_reg),
        .operand  (alu_operand),
        .capacity (cap_reg),
        .result   (alu_result),
        .fits     (alu_fits)
    );

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        pend_valid_next = pend_valid_reg;
        pend_who_next   = pend_who_reg;
        pend_amt_next   = pend_amt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_who_next    = out_who_reg;
        out_amt_next    = out_amt_reg;
        out_rej_next    = out_rej_reg;
        out_last_next   = out_last_reg;
        ram_re          = 1'b0;
        alu_op          = ALU_SUB_SAT;
        alu_operand     = amount;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type)
                    begin
                        held_next  = alu_result;
                        state_next = ST_READ;
                    end
                    else if (occ_reg == FULL_OCC)
                    begin
                        // Drop the request and answer with a lone reject word.
                        out_valid_next = 1'b1;
                        out_who_next   = '0;
                        out_amt_next   = '0;
                        out_rej_next   = 1'b1;
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                        occ_next   = occ_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                if (occ_reg != '0)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_CHECK;
                end
                else if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_who_next    = pend_who_reg;
                    out_amt_next    = pend_amt_reg;
                    out_rej_next    = 1'b0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_CHECK:
            begin
                alu_op      = ALU_ADD;
                alu_operand = rd_amt;
                // Hold the grant back in the pending register so the final one can carry last.
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_who_next   = pend_who_reg;
                        out_amt_next   = pend_amt_reg;
                        out_rej_next   = 1'b0;
                        out_last_next  = !alu_fits;
                    end
                    if (alu_fits)
                    begin
                        pend_valid_next = 1'b1;
                        pend_who_next   = rd_who;
                        pend_amt_next   = rd_amt;
                        held_next       = alu_result;
                        head_next       = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                        occ_next        = occ_reg - 1'b1;
                        state_next      = ST_READ;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cap_reg        <= CAPACITY_RESET;
            held_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            occ_reg        <= occ_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_who_reg <= pend_who_next;
        pend_amt_reg <= pend_amt_next;
        out_who_reg  <= out_who_next;
        out_amt_reg  <= out_amt_next;
        out_rej_reg  <= out_rej_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign grant_requester = out_who_reg;
    assign grant_amount    = out_amt_reg;
    assign rejected        = out_rej_reg;
    assign last_result     = out_last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_OCC)
        else $error("queue occupancy above depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0 || occ_reg == FULL_OCC) |-> head_reg == tail_reg)
        else $error("head and tail disagree with occupancy");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("grant left pending at end of item");

    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rej_reg) |-> (out_last_reg && out_amt_reg == '0))
        else $error("reject word not a lone last word");

    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_rej_reg) |-> out_amt_reg != '0)
        else $error("grant of zero units");

endmodule
